// File: rtl/core/gbpq_pkg.sv
package gbpq_pkg;

   localparam int VERTEX_COUNT_DEF   = 64;
   localparam int MAX_HALF_RANGE_DEF = 31;

   localparam int OPCODE_W     = 3;
   localparam int VERTEX_W     = 6;
   localparam int GAIN_W       = 32;
   localparam int GAIN_FRAC_W  = 16;
   localparam int HALF_RANGE_W = 5;
   localparam int GAIN_SCALE_W = 10;

   typedef logic [OPCODE_W-1:0]       opcode_type;
   typedef logic [VERTEX_W-1:0]       vertex_type;
   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic [HALF_RANGE_W-1:0]   half_range_type;

   localparam logic [GAIN_SCALE_W-1:0] GAIN_SCALE       = 10'd1000;
   localparam half_range_type          HALF_RANGE_RESET = 5'd31;

   localparam opcode_type OP_PUSH         = 3'd0;
   localparam opcode_type OP_ERASE        = 3'd1;
   localparam opcode_type OP_UPDATE       = 3'd2;
   localparam opcode_type OP_POP_MAX      = 3'd3;
   localparam opcode_type OP_CHECK_EMPTY  = 3'd4;
   localparam opcode_type OP_CHECK_MEMBER = 3'd5;
   localparam opcode_type OP_CLEAR        = 3'd6;

endpackage

// File: rtl/core/gain_bucket_priority_queue.sv
// Bucket priority queue for vertex gains; one item is worked on at a time.
// Queries, clear and ignored ops go straight to the result; erase removes the vertex, update and push
// of a queued vertex remove it and insert it again, push of an absent vertex only inserts it, and pop
// max scans the fill memory down from the top bucket, stepping over empty buckets one by one.
// The result becomes valid as the queue returns to idle, in the same cycle that the next item can
// be taken; a held output stalls this. Sync reset empties the queue at once, half_range resets to 31.
module gain_bucket_priority_queue #(
   parameter int VERTEX_COUNT   = gbpq_pkg::VERTEX_COUNT_DEF,
   parameter int MAX_HALF_RANGE = gbpq_pkg::MAX_HALF_RANGE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gbpq_pkg::opcode_type     req_opcode,
   input  gbpq_pkg::vertex_type     req_vertex,
   input  gbpq_pkg::gain_type       req_gain,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output gbpq_pkg::vertex_type     rsp_popped_vertex,
   output logic                     rsp_pop_valid,
   output logic                     rsp_queue_empty,
   output logic                     rsp_is_member,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  gbpq_pkg::half_range_type csr_half_range
);
   import gbpq_pkg::*;

   localparam int NB         = 2 * MAX_HALF_RANGE + 1;
   localparam int VW         = $clog2(VERTEX_COUNT);
   localparam int BW         = $clog2(NB);
   localparam int FW         = $clog2(VERTEX_COUNT + 1);
   localparam int TW         = $clog2(NB + 1);
   localparam int SAW        = BW + VW;
   localparam int SLOT_DEPTH = NB * (2 ** VW);
   localparam int PROD_W     = GAIN_W + GAIN_SCALE_W;
   localparam int Q_W        = PROD_W - GAIN_FRAC_W;
   localparam logic [31:0] MHR32 = 32'(MAX_HALF_RANGE);
   localparam logic [31:0] VC32  = 32'(VERTEX_COUNT);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_RM_B     = 4'd2;
   localparam logic [3:0] S_RM_C     = 4'd3;
   localparam logic [3:0] S_RM_D     = 4'd4;
   localparam logic [3:0] S_INS_A    = 4'd5;
   localparam logic [3:0] S_INS_B    = 4'd6;
   localparam logic [3:0] S_POP_RD   = 4'd7;
   localparam logic [3:0] S_POP_CHK  = 4'd8;
   localparam logic [3:0] S_POP_WR   = 4'd9;
   localparam logic [3:0] S_FINISH   = 4'd10;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [VERTEX_COUNT-1:0] present_ff, present_in;
   logic [NB-1:0]           fill_vld_ff, fill_vld_in;
   logic [TW-1:0]           top_ff, top_in;
   logic [FW-1:0]           queued_ff, queued_in;
   half_range_type          half_range_ff, half_range_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // item payload and scratch
   opcode_type              op_ff, op_in;
   logic [VW-1:0]           vtx_ff, vtx_in;
   logic                    vok_ff, vok_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic                    neg_ff, neg_in;
   logic [BW-1:0]           bkt_ff, bkt_in;
   logic [VW-1:0]           pos_ff, pos_in;
   logic [FW-1:0]           cnt_ff, cnt_in;
   logic [VW-1:0]           pop_vtx_ff, pop_vtx_in;
   logic                    pop_hit_ff, pop_hit_in;
   vertex_type              rsp_vtx_ff, rsp_vtx_in;
   logic                    rsp_pop_ff, rsp_pop_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_member_ff, rsp_member_in;

   // memories
   logic [VW-1:0]           slot_mem [SLOT_DEPTH];
   logic [FW-1:0]           fill_mem [NB];
   logic [BW+VW-1:0]        vtx_mem  [VERTEX_COUNT];
   logic [VW-1:0]           slot_rd_ff;
   logic [FW-1:0]           fill_rd_ff;
   logic [BW+VW-1:0]        vtx_rd_ff;

   logic                    slot_we, fill_we, vtx_we;
   logic [SAW-1:0]          slot_waddr, slot_raddr;
   logic [VW-1:0]           slot_wdata;
   logic [BW-1:0]           fill_waddr, fill_raddr;
   logic [FW-1:0]           fill_wdata;
   logic [VW-1:0]           vtx_waddr, vtx_raddr;
   logic [BW+VW-1:0]        vtx_wdata;

   // datapath helpers
   logic [GAIN_W-1:0]       mag;
   logic [PROD_W-1:0]       prod;
   logic [31:0]             hr32, eff32, q32, qc32, bkt32;
   logic [BW-1:0]           new_bkt, top_bkt;
   logic [FW-1:0]           fill_cur, fill_dec;
   logic [TW-1:0]           ins_top;
   logic                    present_v, w_ok;

   assign mag      = gain_ff[GAIN_W-1] ? (~gain_ff + GAIN_W'(1)) : gain_ff;
   assign prod     = PROD_W'(mag) * PROD_W'(GAIN_SCALE);
   assign hr32     = 32'(half_range_ff);
   assign eff32    = (hr32 == 32'd0) ? 32'd1 : ((hr32 > MHR32) ? MHR32 : hr32);
   assign q32      = 32'(q_ff);
   assign qc32     = (q32 > eff32) ? eff32 : q32;
   assign bkt32    = neg_ff ? (MHR32 - qc32) : (MHR32 + qc32);
   assign new_bkt  = BW'(bkt32);
   assign top_bkt  = BW'(top_ff - TW'(1));
   // bucket fill as seen through its valid bit; bkt_ff names the bucket read last cycle
   assign fill_cur = fill_vld_ff[bkt_ff] ? fill_rd_ff : '0;
   assign fill_dec = fill_cur - FW'(1);
   assign ins_top  = TW'(bkt_ff) + TW'(1);
   assign present_v = vok_ff && present_ff[vtx_ff];
   assign w_ok      = 32'(slot_rd_ff) < VC32;

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_vertex = rsp_vtx_ff;
   assign rsp_pop_valid     = rsp_pop_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_is_member     = rsp_member_ff;

   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      fill_vld_in   = fill_vld_ff;
      top_in        = top_ff;
      queued_in     = queued_ff;
      half_range_in = csr_valid ? csr_half_range : half_range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      op_in         = op_ff;
      vtx_in        = vtx_ff;
      vok_in        = vok_ff;
      gain_in       = gain_ff;
      q_in          = q_ff;
      neg_in        = neg_ff;
      bkt_in        = bkt_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      pop_vtx_in    = pop_vtx_ff;
      pop_hit_in    = pop_hit_ff;
      rsp_vtx_in    = rsp_vtx_ff;
      rsp_pop_in    = rsp_pop_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_member_in = rsp_member_ff;

      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_raddr = {bkt_ff, VW'(fill_dec)};
      fill_we    = 1'b0;
      fill_waddr = '0;
      fill_wdata = '0;
      fill_raddr = bkt_ff;
      vtx_we     = 1'b0;
      vtx_waddr  = '0;
      vtx_wdata  = '0;
      vtx_raddr  = vtx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               vtx_in     = VW'(req_vertex);
               vok_in     = 32'(req_vertex) < VC32;
               gain_in    = req_gain;
               pop_vtx_in = '0;
               pop_hit_in = 1'b0;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // vertex entry read is issued here for the removal path
            case (op_ff)
               OP_PUSH, OP_UPDATE: begin
                  q_in   = prod[PROD_W-1:GAIN_FRAC_W];
                  neg_in = gain_ff[GAIN_W-1];
                  if (!vok_ff || (op_ff == OP_UPDATE && !present_v)) begin
                     state_in = S_FINISH;
                  end else if (present_v) begin
                     state_in = S_RM_B;
                  end else begin
                     state_in = S_INS_A;
                  end
               end
               OP_ERASE: begin
                  state_in = present_v ? S_RM_B : S_FINISH;
               end
               OP_POP_MAX: begin
                  state_in = S_POP_RD;
               end
               OP_CLEAR: begin
                  present_in  = '0;
                  fill_vld_in = '0;
                  top_in      = '0;
                  queued_in   = '0;
                  state_in    = S_FINISH;
               end
               OP_CHECK_EMPTY, OP_CHECK_MEMBER: begin
                  state_in = S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_RM_B: begin
            bkt_in     = vtx_rd_ff[BW+VW-1:VW];
            pos_in     = vtx_rd_ff[VW-1:0];
            fill_raddr = vtx_rd_ff[BW+VW-1:VW];
            state_in   = S_RM_C;
         end
         S_RM_C: begin
            // slot read of the bucket's last entry goes out on the default address
            cnt_in   = fill_dec;
            state_in = S_RM_D;
         end
         S_RM_D: begin
            // last entry fills the hole
            slot_we             = 1'b1;
            slot_waddr          = {bkt_ff, pos_ff};
            slot_wdata          = slot_rd_ff;
            vtx_we              = 1'b1;
            vtx_waddr           = slot_rd_ff;
            vtx_wdata           = {bkt_ff, pos_ff};
            fill_we             = 1'b1;
            fill_waddr          = bkt_ff;
            fill_wdata          = cnt_ff;
            fill_vld_in[bkt_ff] = 1'b1;
            present_in[vtx_ff]  = 1'b0;
            queued_in           = queued_ff - FW'(1);
            state_in            = (op_ff == OP_ERASE) ? S_FINISH : S_INS_A;
         end
         S_INS_A: begin
            bkt_in     = new_bkt;
            fill_raddr = new_bkt;
            state_in   = S_INS_B;
         end
         S_INS_B: begin
            slot_we             = 1'b1;
            slot_waddr          = {bkt_ff, VW'(fill_cur)};
            slot_wdata          = vtx_ff;
            fill_we             = 1'b1;
            fill_waddr          = bkt_ff;
            fill_wdata          = fill_cur + FW'(1);
            fill_vld_in[bkt_ff] = 1'b1;
            vtx_we              = 1'b1;
            vtx_waddr           = vtx_ff;
            vtx_wdata           = {bkt_ff, VW'(fill_cur)};
            present_in[vtx_ff]  = 1'b1;
            queued_in           = queued_ff + FW'(1);
            if (ins_top > top_ff) begin
               top_in = ins_top;
            end
            state_in = S_FINISH;
         end
         S_POP_RD: begin
            // top_ff is biased by one: zero means below the lowest bucket
            if (top_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               bkt_in     = top_bkt;
               fill_raddr = top_bkt;
               state_in   = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            if (fill_cur == '0) begin
               top_in   = top_ff - TW'(1);
               state_in = S_POP_RD;
            end else begin
               cnt_in   = fill_dec;
               state_in = S_POP_WR;
            end
         end
         S_POP_WR: begin
            fill_we    = 1'b1;
            fill_waddr = bkt_ff;
            fill_wdata = cnt_ff;
            pop_vtx_in = slot_rd_ff;
            pop_hit_in = 1'b1;
            if (w_ok && present_ff[slot_rd_ff]) begin
               present_in[slot_rd_ff] = 1'b0;
               queued_in              = queued_ff - FW'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_vtx_in    = VERTEX_W'(pop_vtx_ff);
               rsp_pop_in    = pop_hit_ff;
               rsp_empty_in  = (queued_ff == '0);
               rsp_member_in = present_v;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         present_ff    <= '0;
         fill_vld_ff   <= '0;
         top_ff        <= '0;
         queued_ff     <= '0;
         half_range_ff <= HALF_RANGE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         present_ff    <= present_in;
         fill_vld_ff   <= fill_vld_in;
         top_ff        <= top_in;
         queued_ff     <= queued_in;
         half_range_ff <= half_range_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      vtx_ff        <= vtx_in;
      vok_ff        <= vok_in;
      gain_ff       <= gain_in;
      q_ff          <= q_in;
      neg_ff        <= neg_in;
      bkt_ff        <= bkt_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      pop_vtx_ff    <= pop_vtx_in;
      pop_hit_ff    <= pop_hit_in;
      rsp_vtx_ff    <= rsp_vtx_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_member_ff <= rsp_member_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[fill_raddr];
   end

   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[vtx_waddr] <= vtx_wdata;
      end
      vtx_rd_ff <= vtx_mem[vtx_raddr];
   end

   a_queued_count: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == int'(queued_ff))
      else $error("queued count disagrees with presence bits");

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) <= 32'(NB))
      else $error("top pointer beyond highest bucket");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");

   a_pop_hit_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_WR |-> op_ff == OP_POP_MAX && fill_cur != '0)
      else $error("pop write without a filled bucket");

endmodule
